// ===== sv/suint_pkg.sv =====
// Package with the shared constants, types and controller interface of the sort-unique block.
package suint_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_SCAN,
        ST_DRAIN_RD,
        ST_DRAIN_CMP
    } suint_state_t;

    typedef struct packed {
        logic take;
        logic drop;
        logic seek_rd;
        logic shift;
        logic place;
        logic place_new;
        logic drain_rd;
        logic drain_skip;
        logic drain_emit;
        logic drain_end;
    } suint_cmd_t;

    typedef struct packed {
        logic full;
        logic item_last;
        logic idx_zero;
        logic idx_one;
        logic greater;
        logic equal;
        logic dup;
        logic k_last;
        logic out_free;
    } suint_status_t;

endpackage

// ===== sv/sort_unique_integers_top.sv =====
// Top level of the sort-unique block: collects a set, sorts it and streams its distinct values.
// Each item is placed in sorted order on arrival, after every stored value greater than it
// is shifted up one place; an item that arrives while the set is full is dropped.
// Draining reads the store one entry at a time, skipping duplicates and waiting while the output
// holds an unaccepted result; input is refused from the last item until the last entry is drained.
// Reset (aresetn low at a clock edge) empties the set and clears the overflow flag and output valid.
module sort_unique_integers_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [suint_pkg::DATA_W-1:0]         s_tdata,  // [31:0] value
    input  logic                                s_tlast,  // is_last
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [suint_pkg::OUT_TDATA_W-1:0]    m_tdata,  // [31:0] unique_value, [38:32] unique_count
    output logic                                m_tlast,  // last_unique
    output logic                                m_tuser   // [0] overflow
);
    import suint_pkg::*;

    suint_cmd_t    cmd;
    suint_status_t status;

    suint_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    suint_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/suint_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module suint_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/suint_ctrl.sv =====
// Controller state machine that sequences insertion, overflow handling and draining.
module suint_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tlast,
    output logic                    s_tready,
    input  suint_pkg::suint_status_t status,
    output suint_pkg::suint_cmd_t    cmd
);
    import suint_pkg::*;

    suint_state_t state_reg;
    suint_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (status.full) begin
                        cmd.drop = 1'b1;
                        state_next = s_tlast ? ST_DRAIN_RD : ST_IDLE;
                    end else begin
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                if (status.idx_zero) begin
                    cmd.place = 1'b1;
                    cmd.place_new = 1'b1;
                    state_next = status.item_last ? ST_DRAIN_RD : ST_IDLE;
                end else begin
                    cmd.seek_rd = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.greater) begin
                    cmd.shift = 1'b1;
                    state_next = status.idx_one ? ST_SEEK : ST_SCAN;
                end else begin
                    cmd.place = 1'b1;
                    cmd.place_new = !status.equal;
                    state_next = status.item_last ? ST_DRAIN_RD : ST_IDLE;
                end
            end
            ST_DRAIN_RD: begin
                cmd.drain_rd = 1'b1;
                state_next = ST_DRAIN_CMP;
            end
            ST_DRAIN_CMP: begin
                if (status.dup || status.out_free) begin
                    cmd.drain_skip = status.dup;
                    cmd.drain_emit = !status.dup;
                    if (status.k_last) begin
                        cmd.drain_end = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/suint_datapath.sv =====
// Datapath with the value store, insertion shifter, counters and output register.
module suint_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  suint_pkg::suint_cmd_t                   cmd,
    output suint_pkg::suint_status_t                status,
    input  logic [suint_pkg::DATA_W-1:0]            s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [suint_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tuser
);
    import suint_pkg::*;

    logic [DATA_W-1:0] item_reg;
    logic              item_last_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  uniq_reg;
    logic              drop_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  emit_reg;
    logic [DATA_W-1:0] prev_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    suint_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        ram_we    = cmd.place || cmd.shift;
        ram_waddr = idx_reg;
        ram_wdata = cmd.shift ? ram_rdata : item_reg;
        ram_re    = cmd.seek_rd || cmd.drain_rd || (cmd.shift && !status.idx_one);
        if (cmd.drain_rd) begin
            ram_raddr = k_reg;
        end else if (cmd.shift) begin
            ram_raddr = idx_reg - IDX_W'(2);
        end else begin
            ram_raddr = idx_reg - IDX_W'(1);
        end
    end

    always_comb begin
        status.full      = (fill_reg == CNT_W'(MAX_ITEMS));
        status.item_last = item_last_reg;
        status.idx_zero  = (idx_reg == '0);
        status.idx_one   = (idx_reg == IDX_W'(1));
        status.greater   = ($signed(ram_rdata) > $signed(item_reg));
        status.equal     = (ram_rdata == item_reg);
        status.dup       = (k_reg != '0) && (ram_rdata == prev_reg);
        status.k_last    = ((CNT_W'(k_reg) + CNT_W'(1)) == fill_reg);
        status.out_free  = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg      <= s_tdata;
            item_last_reg <= s_tlast;
            idx_reg       <= fill_reg[IDX_W-1:0];
        end else if (cmd.shift) begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
        if (cmd.drain_emit) begin
            prev_reg <= ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            uniq_reg <= '0;
            drop_reg <= 1'b0;
            k_reg    <= '0;
            emit_reg <= '0;
        end else begin
            if (cmd.drain_end) begin
                fill_reg <= '0;
                uniq_reg <= '0;
                drop_reg <= 1'b0;
                k_reg    <= '0;
                emit_reg <= '0;
            end else begin
                if (cmd.place) begin
                    fill_reg <= fill_reg + CNT_W'(1);
                    uniq_reg <= uniq_reg + CNT_W'(cmd.place_new);
                end
                if (cmd.drop) begin
                    drop_reg <= 1'b1;
                end
                if (cmd.drain_skip || cmd.drain_emit) begin
                    k_reg <= k_reg + IDX_W'(1);
                end
                if (cmd.drain_emit) begin
                    emit_reg <= emit_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.drain_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.drain_emit) begin
            out_value_reg <= ram_rdata;
            out_count_reg <= uniq_reg;
            out_last_reg  <= ((CNT_W'(emit_reg) + CNT_W'(1)) == uniq_reg);
            out_ovf_reg   <= drop_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DATA_W - CNT_W){1'b0}}, out_count_reg, out_value_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule
